### rtl/alr_pkg.sv
// shared types and constants for the antialiased line rasterizer
// coordinate widths, item structs, mode and command codes
// no dependencies
package alr_pkg;

    localparam int COORD_BITS = 12;
    localparam int PIX_BITS = COORD_BITS + 1;
    localparam int FRAC_BITS_DEF = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam logic [7:0] FULL_ALPHA = 8'hFF;
    localparam logic [7:0] LINE_ALPHA_RST = 8'hFF;

    // command codes of the input item
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_SOLID_X = 2'd1,
        MODE_SOLID_Y = 2'd2,
        MODE_WU      = 2'd3
    } draw_mode_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        OP_STEP       = 2'd0,
        OP_LOAD_SOLID = 2'd1,
        OP_LOAD_WU    = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        BK_READY = 2'd0,
        BK_DIV   = 2'd1,
        BK_PAIR  = 2'd2
    } back_state_t;

    typedef struct packed {
        logic                  cmd;
        logic [COORD_BITS-1:0] x_a;
        logic [COORD_BITS-1:0] y_a;
        logic [COORD_BITS-1:0] x_b;
        logic [COORD_BITS-1:0] y_b;
    } in_item_t;

    typedef struct packed {
        logic [PIX_BITS-1:0] pix_x;
        logic [PIX_BITS-1:0] pix_y;
        logic [7:0]          coverage;
        logic                last;
        logic                line_done;
    } out_item_t;

    // classified item handed from front to back
    typedef struct packed {
        op_t                   op;
        draw_mode_t            mode;
        logic [COORD_BITS-1:0] maj_start;
        logic [COORD_BITS-1:0] maj_end;
        logic [COORD_BITS-1:0] minor;
        dir_t                  dir;
        logic                  steep;
        logic                  neg;
        logic [COORD_BITS-1:0] num;
        logic [COORD_BITS-1:0] den;
    } qitem_t;

endpackage

### rtl/alr_front.sv
// front end: takes input items and classifies loads into solid or wu setups
// depends on alr_pkg
module alr_front (
    input  alr_pkg::in_item_t s_data,
    input  logic              s_valid,
    output logic              s_ready,
    output alr_pkg::qitem_t   q_item,
    output logic              q_push,
    input  logic              q_full
);
    import alr_pkg::*;

    logic                  swap;
    logic [COORD_BITS-1:0] x1, y1, x2, y2;
    logic [COORD_BITS-1:0] dx, ady;
    logic                  neg;
    logic                  vert;
    logic                  horiz;
    logic [COORD_BITS-1:0] sa, sb;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        swap = s_data.x_a > s_data.x_b;
        x1   = swap ? s_data.x_b : s_data.x_a;
        y1   = swap ? s_data.y_b : s_data.y_a;
        x2   = swap ? s_data.x_a : s_data.x_b;
        y2   = swap ? s_data.y_a : s_data.y_b;
        dx   = x2 - x1;
        neg  = y2 < y1;
        ady  = neg ? (y1 - y2) : (y2 - y1);
        vert  = s_data.x_a == s_data.x_b;
        horiz = s_data.y_a == s_data.y_b;
        sa    = vert ? s_data.y_a : s_data.x_a;
        sb    = vert ? s_data.y_b : s_data.x_b;

        q_item.op        = OP_STEP;
        q_item.mode      = MODE_IDLE;
        q_item.maj_start = x1;
        q_item.maj_end   = x2;
        q_item.minor     = y1;
        q_item.dir       = DIR_NONE;
        q_item.steep     = 1'b0;
        q_item.neg       = neg;
        q_item.num       = ady;
        q_item.den       = dx;

        if (s_data.cmd == CMD_LOAD) begin
            if (vert || horiz) begin
                // axis-aligned, single point counts as vertical
                q_item.op        = OP_LOAD_SOLID;
                q_item.mode      = vert ? MODE_SOLID_Y : MODE_SOLID_X;
                q_item.maj_start = (sa < sb) ? sa : sb;
                q_item.maj_end   = (sa < sb) ? sb : sa;
                q_item.minor     = vert ? s_data.x_a : s_data.y_a;
            end else if (dx == ady) begin
                q_item.op   = OP_LOAD_SOLID;
                q_item.mode = MODE_SOLID_X;
                q_item.dir  = neg ? DIR_DOWN : DIR_UP;
            end else begin
                q_item.op    = OP_LOAD_WU;
                q_item.mode  = MODE_WU;
                q_item.steep = ady > dx;
                if (ady > dx) begin
                    q_item.maj_start = neg ? y2 : y1;
                    q_item.maj_end   = neg ? y1 : y2;
                    q_item.minor     = neg ? x2 : x1;
                    q_item.num       = dx;
                    q_item.den       = ady;
                end
            end
        end
    end

endmodule

### rtl/alr_fifo.sv
// short queue of classified items between front and back
// depends on alr_pkg
module alr_fifo #(
    parameter int DEPTH = alr_pkg::QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_en,
    input  alr_pkg::qitem_t wr_item,
    output logic            full,
    input  logic            rd_en,
    output alr_pkg::qitem_t rd_item,
    output logic            empty
);
    import alr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    qitem_t             mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full    = count_reg == CNT_W'(DEPTH);
    assign empty   = count_reg == '0;
    assign rd_item = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en) begin
            count_next = count_reg + 1'b1;
        end else if (rd_en && !wr_en) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr_en && full && !rd_en))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> !empty)
        else $error("queue read while empty");

    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && !rd_en) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow a write");

endmodule

### rtl/alr_back.sv
// back end: holds the line walk, runs the slope divider, drives result items
// depends on alr_pkg
module alr_back #(
    parameter int FRAC_BITS = alr_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  alr_pkg::qitem_t    q_item,
    input  logic               q_valid,
    output logic               q_pop,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata,
    output logic               m_valid,
    input  logic               m_ready,
    output alr_pkg::out_item_t m_data
);
    import alr_pkg::*;

    localparam int FIX_W   = PIX_BITS + FRAC_BITS;
    localparam int SLOPE_W = FRAC_BITS + 1;
    localparam int CNT_W   = (FRAC_BITS > 1) ? $clog2(FRAC_BITS) : 1;

    back_state_t           state_reg, state_next;
    draw_mode_t            mode_reg, mode_next;
    logic [PIX_BITS-1:0]   pos_reg, pos_next;
    logic [PIX_BITS-1:0]   end_reg, end_next;
    logic [PIX_BITS-1:0]   sminor_reg, sminor_next;
    dir_t                  dir_reg, dir_next;
    logic                  steep_reg, steep_next;
    logic [FIX_W-1:0]      fix_reg, fix_next;
    logic [SLOPE_W-1:0]    slope_reg, slope_next;
    logic                  neg_reg, neg_next;
    logic [COORD_BITS-1:0] den_reg, den_next;
    logic [COORD_BITS-1:0] rem_reg, rem_next;
    logic [FRAC_BITS-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [7:0]            alpha_reg, alpha_next;
    logic                  out_valid_reg, out_valid_next;
    out_item_t             out_reg, out_next;
    out_item_t             pend_reg, pend_next;

    logic                  out_free;
    logic [COORD_BITS:0]   rem_shift;
    logic                  div_ge;
    logic [COORD_BITS:0]   rem_sub;
    logic [COORD_BITS-1:0] rem_step;
    logic [FRAC_BITS-1:0]  quo_step;
    logic                  div_last;
    logic [SLOPE_W-1:0]    slope_new;
    logic [FIX_W-1:0]      slope_ext;
    logic [FIX_W-1:0]      slope_new_ext;
    logic [PIX_BITS-1:0]   ip;
    logic [PIX_BITS-1:0]   ip_inc;
    logic [FRAC_BITS-1:0]  frac;
    logic [FRAC_BITS:0]    inv;
    logic [FRAC_BITS+8:0]  prod0;
    logic [FRAC_BITS+7:0]  prod1;
    logic [7:0]            cov0, cov1;
    logic [PIX_BITS-1:0]   pos_inc;
    logic                  wu_done;
    logic                  solid_done;

    assign out_free = !out_valid_reg || m_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    // restoring divider, one quotient bit per cycle
    assign rem_shift = {rem_reg, 1'b0};
    assign div_ge    = rem_shift >= {1'b0, den_reg};
    assign rem_sub   = rem_shift - {1'b0, den_reg};
    assign rem_step  = div_ge ? rem_sub[COORD_BITS-1:0] : rem_shift[COORD_BITS-1:0];
    assign quo_step  = {quo_reg[FRAC_BITS-2:0], div_ge};
    assign div_last  = cnt_reg == '0;
    assign slope_new = neg_reg ? (SLOPE_W'(0) - {1'b0, quo_step}) : {1'b0, quo_step};

    assign slope_ext     = {{(PIX_BITS-1){slope_reg[SLOPE_W-1]}}, slope_reg};
    assign slope_new_ext = {{(PIX_BITS-1){slope_new[SLOPE_W-1]}}, slope_new};

    // coverage = 255 * weight >> FRAC_BITS, as shift and subtract
    assign ip     = fix_reg[FIX_W-1:FRAC_BITS];
    assign ip_inc = ip + 1'b1;
    assign frac   = fix_reg[FRAC_BITS-1:0];
    assign inv    = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, frac};
    assign prod0  = {inv, 8'h00} - {8'h00, inv};
    assign prod1  = {frac, 8'h00} - {8'h00, frac};
    assign cov0   = prod0[FRAC_BITS+7:FRAC_BITS];
    assign cov1   = prod1[FRAC_BITS+7:FRAC_BITS];

    assign pos_inc    = pos_reg + 1'b1;
    assign wu_done    = pos_inc == end_reg;
    assign solid_done = pos_reg == end_reg;

    assign q_pop = (state_reg == BK_READY) && q_valid && out_free;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_READY: begin
                if (q_pop) begin
                    if (q_item.op == OP_LOAD_WU) begin
                        state_next = BK_DIV;
                    end else if (q_item.op == OP_STEP && mode_reg == MODE_WU) begin
                        state_next = BK_PAIR;
                    end
                end
            end
            BK_DIV: begin
                if (div_last) begin
                    state_next = BK_READY;
                end
            end
            BK_PAIR: begin
                if (out_free) begin
                    state_next = BK_READY;
                end
            end
            default: state_next = BK_READY;
        endcase
    end

    // datapath and outputs
    always_comb begin
        mode_next      = mode_reg;
        pos_next       = pos_reg;
        end_next       = end_reg;
        sminor_next    = sminor_reg;
        dir_next       = dir_reg;
        steep_next     = steep_reg;
        fix_next       = fix_reg;
        slope_next     = slope_reg;
        neg_next       = neg_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        alpha_next     = cfg_we ? cfg_wdata : alpha_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        pend_next      = pend_reg;

        unique case (state_reg)
            BK_READY: begin
                if (q_pop) begin
                    unique case (q_item.op)
                        OP_LOAD_SOLID: begin
                            mode_next   = q_item.mode;
                            pos_next    = {1'b0, q_item.maj_start};
                            end_next    = {1'b0, q_item.maj_end};
                            sminor_next = {1'b0, q_item.minor};
                            dir_next    = q_item.dir;
                        end
                        OP_LOAD_WU: begin
                            mode_next  = MODE_WU;
                            pos_next   = {1'b0, q_item.maj_start};
                            end_next   = {1'b0, q_item.maj_end};
                            steep_next = q_item.steep;
                            fix_next   = {1'b0, q_item.minor, {FRAC_BITS{1'b0}}};
                            neg_next   = q_item.neg;
                            den_next   = q_item.den;
                            rem_next   = q_item.num;
                            quo_next   = '0;
                            cnt_next   = CNT_W'(FRAC_BITS - 1);
                        end
                        OP_STEP: begin
                            unique case (mode_reg)
                                MODE_SOLID_X, MODE_SOLID_Y: begin
                                    out_valid_next     = 1'b1;
                                    out_next.pix_x     = (mode_reg == MODE_SOLID_X) ?
                                                         pos_reg : sminor_reg;
                                    out_next.pix_y     = (mode_reg == MODE_SOLID_X) ?
                                                         sminor_reg : pos_reg;
                                    out_next.coverage  = alpha_reg;
                                    out_next.last      = 1'b1;
                                    out_next.line_done = solid_done;
                                    if (solid_done) begin
                                        mode_next = MODE_IDLE;
                                    end else begin
                                        pos_next = pos_inc;
                                        if (dir_reg == DIR_UP) begin
                                            sminor_next = sminor_reg + 1'b1;
                                        end else if (dir_reg == DIR_DOWN) begin
                                            sminor_next = sminor_reg - 1'b1;
                                        end
                                    end
                                end
                                MODE_WU: begin
                                    out_valid_next      = 1'b1;
                                    out_next.pix_x      = steep_reg ? ip : pos_reg;
                                    out_next.pix_y      = steep_reg ? pos_reg : ip;
                                    out_next.coverage   = cov0;
                                    out_next.last       = 1'b0;
                                    out_next.line_done  = wu_done;
                                    pend_next.pix_x     = steep_reg ? ip_inc : pos_reg;
                                    pend_next.pix_y     = steep_reg ? pos_reg : ip_inc;
                                    pend_next.coverage  = cov1;
                                    pend_next.last      = 1'b1;
                                    pend_next.line_done = wu_done;
                                    pos_next            = pos_inc;
                                    fix_next            = fix_reg + slope_ext;
                                    if (wu_done) begin
                                        mode_next = MODE_IDLE;
                                    end
                                end
                                default: begin
                                    // no line active: the step gives nothing
                                end
                            endcase
                        end
                        default: begin
                        end
                    endcase
                end
            end
            BK_DIV: begin
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg - 1'b1;
                if (div_last) begin
                    slope_next = slope_new;
                    // steep walk starts one gradient past the endpoint
                    if (steep_reg) begin
                        fix_next = fix_reg + slope_new_ext;
                    end
                end
            end
            BK_PAIR: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_next       = pend_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_READY;
            mode_reg      <= MODE_IDLE;
            alpha_reg     <= LINE_ALPHA_RST;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            alpha_reg     <= alpha_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        end_reg    <= end_next;
        sminor_reg <= sminor_next;
        dir_reg    <= dir_next;
        steep_reg  <= steep_next;
        fix_reg    <= fix_next;
        slope_reg  <= slope_next;
        neg_reg    <= neg_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
        out_reg    <= out_next;
        pend_reg   <= pend_next;
    end

    a_pair_has_first: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BK_PAIR |-> out_valid_reg)
        else $error("second pixel pending without first pixel shown");

    a_div_in_wu: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BK_DIV |-> mode_reg == MODE_WU)
        else $error("divider running outside a wu setup");

    a_first_of_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_reg.last) |-> state_reg == BK_PAIR)
        else $error("non-last pixel shown with no second pixel pending");

    a_wu_not_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_WU |-> pos_reg != end_reg)
        else $error("wu walk sitting on its excluded end");

endmodule

### rtl/antialiased_line_rasterizer.sv
// a step's first pixel goes through the item queue and the back end's out_reg before it shows on m_valid
// throughput: solid lines one step per cycle while m_ready holds; a wu step gives two pixels in turn
// and no new item is taken until its second pixel is out; a wu load holds the back end in the serial
// slope divider until the slope quotient is complete; loads and steps wait in the item queue meanwhile
// reset: synchronous active-low aresetn; no line active, line_alpha back to 255
// top level: front classifier, item queue and back end; depends on alr_pkg
module antialiased_line_rasterizer #(
    parameter int FRAC_BITS = alr_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  alr_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output alr_pkg::out_item_t m_data,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata
);
    import alr_pkg::*;

    qitem_t front_item;
    qitem_t back_item;
    logic   q_push;
    logic   q_full;
    logic   q_pop;
    logic   q_empty;

    alr_front u_front (
        .s_data  (s_data),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .q_item  (front_item),
        .q_push  (q_push),
        .q_full  (q_full)
    );

    alr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (q_push),
        .wr_item (front_item),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_item (back_item),
        .empty   (q_empty)
    );

    alr_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_item    (back_item),
        .q_valid   (!q_empty),
        .q_pop     (q_pop),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
